// ===== sv/midi_running_status_parser_assert.svh =====
// ----------------------------------------------------------------------------
// midi running status parser assertion macros
// shared concurrent assertion forms used by the parser rtl
// ----------------------------------------------------------------------------
`ifndef MIDI_RUNNING_STATUS_PARSER_ASSERT_SVH
`define MIDI_RUNNING_STATUS_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MRSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MRSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsp_pkg
// byte codes and types for the midi running status parser
// ----------------------------------------------------------------------------
package mrsp_pkg;

   typedef logic [7:0] midi_byte_type;
   typedef logic [3:0] channel_type;

   // byte codes
   localparam midi_byte_type EXCL_START   = 8'hF0;
   localparam midi_byte_type EXCL_END     = 8'hF7;
   localparam midi_byte_type REALTIME_MIN = 8'hF8;
   localparam midi_byte_type ONE_DATA_LO  = 8'hC0;
   localparam midi_byte_type ONE_DATA_HI  = 8'hDF;
   localparam midi_byte_type STATUS_MIN   = 8'h80;
   localparam midi_byte_type NO_STATUS    = 8'h00;
   localparam midi_byte_type DATA_RESET   = 8'hFF;
   localparam midi_byte_type NIBBLE_MASK  = 8'h0F;

   // one result item
   typedef struct packed {
      logic          channel_match;
      logic          message_valid;
      midi_byte_type single_value;
      midi_byte_type note_velocity;
      midi_byte_type note_key;
      midi_byte_type status_byte;
   } rsp_type;

   // status byte that takes a single data byte
   function automatic logic is_one_data(input midi_byte_type status);
      return (status >= ONE_DATA_LO) && (status <= ONE_DATA_HI);
   endfunction

endpackage

// ===== sv/midi_running_status_parser.sv =====
// ----------------------------------------------------------------------------
// midi running status parser
// decodes midi bytes into channel messages, without back-pressure one byte a cycle
// ----------------------------------------------------------------------------
// Every byte accepted on the req channel produces exactly one transfer on the
// rsp channel, in order. While rsp_tready is high the block accepts one byte
// per clock: the byte decision is a single combinational pass from the parser
// state registers into the result register, so a new byte is accepted in the
// same cycle the previous result is taken, and while the result register is
// empty, with rsp_tvalid set in the next cycle. rsp_tuser[0] flags a byte that
// completed a channel message; the data fields always report the running
// status and the last key, velocity and single value. listen_channel is set
// through the csr port and should only be changed while no result is pending.
module midi_running_status_parser (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_wr_en,
   input  mrsp_pkg::channel_type     csr_wr_data,   // listen_channel
   // received bytes
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  mrsp_pkg::midi_byte_type   req_tdata,     // [7:0] rx_byte
   // parsed results
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,     // [7:0] status_byte, [15:8] note_key,
                                                    // [23:16] note_velocity, [31:24] single_value
   output logic [1:0]                rsp_tuser      // [0] message_valid, [1] channel_match
);
   import mrsp_pkg::*;

   // configuration register
   channel_type   listen_channel_ff;

   // parser state
   midi_byte_type running_status_ff, running_status_in;
   logic          awaiting_third_ff, awaiting_third_in;
   logic          in_exclusive_ff, in_exclusive_in;
   midi_byte_type key_ff, key_in;
   midi_byte_type velocity_ff, velocity_in;
   midi_byte_type value_ff, value_in;
   logic          msg_valid_in;

   // result register
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   logic          req_xfer;
   logic          rsp_xfer;

   // take a byte whenever the result slot is free or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;

   // byte decision
   always_comb begin
      running_status_in = running_status_ff;
      awaiting_third_in = awaiting_third_ff;
      in_exclusive_in   = in_exclusive_ff;
      key_in            = key_ff;
      velocity_in       = velocity_ff;
      value_in          = value_ff;
      msg_valid_in      = 1'b0;

      // real-time bytes leave everything untouched
      if (req_tdata < REALTIME_MIN) begin
         if (req_tdata == EXCL_END) begin
            // end of sysex, status gone
            in_exclusive_in   = 1'b0;
            running_status_in = NO_STATUS;
            awaiting_third_in = 1'b0;
         end else if ((req_tdata == EXCL_START) || in_exclusive_ff) begin
            // sysex start or sysex payload
            in_exclusive_in   = 1'b1;
            running_status_in = NO_STATUS;
            awaiting_third_in = 1'b0;
         end else if (req_tdata >= STATUS_MIN) begin
            // new running status
            running_status_in = req_tdata;
            awaiting_third_in = 1'b0;
         end else if (awaiting_third_ff) begin
            // velocity closes a three-byte message
            awaiting_third_in = 1'b0;
            velocity_in       = req_tdata;
            msg_valid_in      = 1'b1;
         end else if (running_status_ff != NO_STATUS) begin
            if (is_one_data(running_status_ff)) begin
               // program change or channel pressure
               value_in     = req_tdata;
               msg_valid_in = 1'b1;
            end else begin
               // key, velocity still to come
               awaiting_third_in = 1'b1;
               key_in            = req_tdata;
            end
         end
         // data byte with no status is dropped
      end
   end

   // result built from the next-state values
   always_comb begin
      rsp_in.message_valid = msg_valid_in;
      rsp_in.status_byte   = running_status_in;
      rsp_in.note_key      = key_in;
      rsp_in.note_velocity = velocity_in;
      rsp_in.single_value  = value_in;
      rsp_in.channel_match =
         ((running_status_in & NIBBLE_MASK) == {4'b0000, listen_channel_ff});
   end

   // control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         listen_channel_ff <= '0;
         running_status_ff <= NO_STATUS;
         awaiting_third_ff <= 1'b0;
         in_exclusive_ff   <= 1'b0;
         key_ff            <= DATA_RESET;
         velocity_ff       <= DATA_RESET;
         value_ff          <= NO_STATUS;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            listen_channel_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            running_status_ff <= running_status_in;
            awaiting_third_ff <= awaiting_third_in;
            in_exclusive_ff   <= in_exclusive_in;
            key_ff            <= key_in;
            velocity_ff       <= velocity_in;
            value_ff          <= value_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff      <= 1'b0;
         end
      end
   end

   // result payload, loaded on each req transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.single_value, rsp_ff.note_velocity,
                        rsp_ff.note_key, rsp_ff.status_byte};
   assign rsp_tuser  = {rsp_ff.channel_match, rsp_ff.message_valid};

   // checks
`include "midi_running_status_parser_assert.svh"

   `MRSP_ASSERT_IMPL(a_third_needs_two_data, clock, reset, awaiting_third_ff, (running_status_ff != NO_STATUS) && !is_one_data(running_status_ff), "waiting for velocity without a two-data status")
   `MRSP_ASSERT_IMPL(a_sysex_no_status, clock, reset, in_exclusive_ff, (running_status_ff == NO_STATUS) && !awaiting_third_ff, "status held during sysex")
   `MRSP_ASSERT_IMPL(a_msg_has_status, clock, reset, rsp_valid_ff && rsp_ff.message_valid, rsp_ff.status_byte != NO_STATUS, "message flagged with no running status")
   `MRSP_ASSERT_NEXT(a_xfer_loads_result, clock, reset, req_xfer, rsp_valid_ff && (rsp_ff.status_byte == running_status_ff), "accepted byte did not reach the result register")

endmodule
